// ===== design/step_toward_target_3d_top_defines.svh =====
// assertion macros for the step toward target block
`ifndef STEP_TOWARD_TARGET_3D_TOP_DEFINES_SVH
`define STEP_TOWARD_TARGET_3D_TOP_DEFINES_SVH

// same-cycle implication, muted in reset
`define STT3D_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
    else $error("stt3d check failed");

// next-cycle implication, muted in reset
`define STT3D_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
    else $error("stt3d check failed");

// next-cycle implication, live through reset
`define STT3D_ASSERT_NEXT_ALWAYS(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("stt3d check failed");

`endif

// ===== design/stt3d_pkg.sv =====
package stt3d_pkg;

  // inverse aspect register, unsigned q2.16
  localparam int ASPECT_W    = 18;
  localparam int ASPECT_FRAC = 16;
  localparam logic [ASPECT_W-1:0] ASPECT_RESET = 18'd65536;

endpackage

// ===== design/stt3d_if.sv =====
interface stt3d_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] from_x;
  logic signed [COORD_WIDTH-1:0] from_y;
  logic signed [COORD_WIDTH-1:0] from_z;
  logic signed [COORD_WIDTH-1:0] to_x;
  logic signed [COORD_WIDTH-1:0] to_y;
  logic signed [COORD_WIDTH-1:0] to_z;
  logic signed [COORD_WIDTH-1:0] step_len;

  modport source (
    output valid, pos_x, pos_y, pos_z, from_x, from_y, from_z, to_x, to_y, to_z, step_len,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, from_x, from_y, from_z, to_x, to_y, to_z, step_len,
    output ready
  );
endinterface

interface stt3d_out_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] new_x;
  logic signed [COORD_WIDTH-1:0] new_y;
  logic signed [COORD_WIDTH-1:0] new_z;
  logic                          zero_distance;

  modport source (
    output valid, new_x, new_y, new_z, zero_distance,
    input  ready
  );
  modport sink (
    input  valid, new_x, new_y, new_z, zero_distance,
    output ready
  );
endinterface

// ===== design/step_toward_target_3d_top.sv =====
// throughput: one word per cycle; the whole pipeline advances together and holds on a stall
// the square root (one root bit per stage) and the three dividers (one quotient bit per
// stage) set the depth
// reset: synchronous active-low rst_n clears all valid bits and sets inverse_aspect to 1.0
module step_toward_target_3d_top
  import stt3d_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [ASPECT_W-1:0] cfg_wdata,
  stt3d_in_if.sink            in_ch,
  stt3d_out_if.source         out_ch
);

  // widths, all following from the coordinate width
  localparam int W    = COORD_WIDTH;
  localparam int MW   = W + 1;                          // magnitude of a difference
  localparam int SXW  = MW + ASPECT_W - ASPECT_FRAC;    // scaled x magnitude
  localparam int RW   = SXW + 1;                        // square root width
  localparam int SUMW = 2 * RW;                         // radicand, padded to even
  localparam int NW   = W + MW;                         // |step| * |diff|
  localparam int QW   = W + 3;                          // quotient bits computed
  localparam int HW   = NW - QW;                        // numerator bits above quotient
  localparam int OW   = W + 4;                          // final sum before clamping

  typedef struct packed {
    logic signed [W-1:0] pos;
    logic                neg;    // step moves the position upward
    logic [NW-1:0]       num;
  } axis_t;

  typedef struct packed {
    logic [RW:0]     rem;
    logic [RW-1:0]   root;
    logic [SUMW-1:0] rad;
    axis_t [2:0]     ax;
  } sq_t;

  typedef struct packed {
    logic signed [W-1:0] pos;
    logic                neg;
    logic                ovf;    // quotient beyond the computed bits
    logic [RW-1:0]       rem;
    logic [QW-1:0]       qn;     // numerator bits shift out, quotient bits shift in
  } dax_t;

  typedef struct packed {
    logic [RW-1:0] len;
    logic          zero;
    dax_t [2:0]    ax;
  } dv_t;

  // global advance: the output register is free or being emptied
  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // configuration register
  logic [ASPECT_W-1:0] ia_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ia_r <= ASPECT_RESET;
    end else if (cfg_we) begin
      ia_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- stage 0
  // register the word and form origin minus target per axis
  logic                s0_v_r;
  logic signed [W-1:0] s0_pos_r  [3];
  logic signed [W:0]   s0_diff_r [3];
  logic signed [W-1:0] s0_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_pos_r[0]  <= in_ch.pos_x;
      s0_pos_r[1]  <= in_ch.pos_y;
      s0_pos_r[2]  <= in_ch.pos_z;
      s0_diff_r[0] <= (W+1)'(in_ch.from_x) - (W+1)'(in_ch.to_x);
      s0_diff_r[1] <= (W+1)'(in_ch.from_y) - (W+1)'(in_ch.to_y);
      s0_diff_r[2] <= (W+1)'(in_ch.from_z) - (W+1)'(in_ch.to_z);
      s0_step_r    <= in_ch.step_len;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // magnitudes, aspect scaling of x, squares of y and z, step numerators
  logic [W-1:0]             s1_su;
  logic [W-1:0]             s1_smag;
  logic [MW-1:0]            s1_du   [3];
  logic [MW-1:0]            s1_dmag [3];
  logic [MW+ASPECT_W-1:0]   s1_px;
  logic [2*MW-1:0]          s1_sqy_nxt, s1_sqz_nxt;
  axis_t [2:0]              s1_ax_nxt;

  always_comb begin
    s1_su   = s0_step_r;
    s1_smag = s1_su[W-1] ? (~s1_su + 1'b1) : s1_su;
    for (int a = 0; a < 3; a++) begin
      s1_du[a]            = s0_diff_r[a];
      s1_dmag[a]          = s1_du[a][MW-1] ? (~s1_du[a] + 1'b1) : s1_du[a];
      s1_ax_nxt[a].pos    = s0_pos_r[a];
      s1_ax_nxt[a].neg    = s1_su[W-1] ^ s1_du[a][MW-1];
      s1_ax_nxt[a].num    = NW'(s1_smag) * NW'(s1_dmag[a]);
    end
    s1_px      = (MW+ASPECT_W)'(s1_dmag[0]) * (MW+ASPECT_W)'(ia_r);
    s1_sqy_nxt = (2*MW)'(s1_dmag[1]) * (2*MW)'(s1_dmag[1]);
    s1_sqz_nxt = (2*MW)'(s1_dmag[2]) * (2*MW)'(s1_dmag[2]);
  end

  logic            s1_v_r;
  logic [SXW-1:0]  s1_sx_r;
  logic [2*MW-1:0] s1_sqy_r, s1_sqz_r;
  axis_t [2:0]     s1_ax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sx_r  <= s1_px[MW+ASPECT_W-1:ASPECT_FRAC];   // truncate toward zero
      s1_sqy_r <= s1_sqy_nxt;
      s1_sqz_r <= s1_sqz_nxt;
      s1_ax_r  <= s1_ax_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // square of scaled x, partial sum of y and z squares
  logic              s2_v_r;
  logic [2*SXW-1:0]  s2_sqx_r;
  logic [2*MW:0]     s2_syz_r;
  axis_t [2:0]       s2_ax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sqx_r <= (2*SXW)'(s1_sx_r) * (2*SXW)'(s1_sx_r);
      s2_syz_r <= (2*MW+1)'(s1_sqy_r) + (2*MW+1)'(s1_sqz_r);
      s2_ax_r  <= s1_ax_r;
    end
  end

  // ---------------------------------------------------------------- square root
  // sq_r[0] holds the full sum of squares; each later stage settles one root bit
  sq_t  sq_r   [RW+1];
  logic sq_v_r [RW+1];
  sq_t  sq0_nxt;

  always_comb begin
    sq0_nxt      = '0;
    sq0_nxt.rad  = SUMW'(s2_sqx_r) + SUMW'(s2_syz_r);
    sq0_nxt.ax   = s2_ax_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= sq0_nxt;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW+2:0] t;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          take;
    sq_t           sq_nxt;

    always_comb begin
      t              = {sq_r[k].rem, sq_r[k].rad[SUMW-1 -: 2]};
      trial          = {1'b0, sq_r[k].root, 2'b01};
      diff           = t - trial;
      take           = (t >= trial);
      sq_nxt         = sq_r[k];
      sq_nxt.rad     = {sq_r[k].rad[SUMW-3:0], 2'b00};
      sq_nxt.rem     = take ? diff[RW:0] : t[RW:0];
      sq_nxt.root    = {sq_r[k].root[RW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k+1] <= sq_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- divide
  // dv_r[0] checks for a quotient past the computed bits, later stages give one bit each
  dv_t  dv_r   [QW+1];
  logic dv_v_r [QW+1];
  dv_t  dv0_nxt;

  always_comb begin
    dv0_nxt      = '0;
    dv0_nxt.len  = sq_r[RW].root;
    dv0_nxt.zero = (sq_r[RW].root == '0);
    for (int a = 0; a < 3; a++) begin
      dv0_nxt.ax[a].pos = sq_r[RW].ax[a].pos;
      dv0_nxt.ax[a].neg = sq_r[RW].ax[a].neg;
      dv0_nxt.ax[a].rem = RW'(sq_r[RW].ax[a].num[NW-1 -: HW]);
      dv0_nxt.ax[a].ovf = (RW'(sq_r[RW].ax[a].num[NW-1 -: HW]) >= sq_r[RW].root);
      dv0_nxt.ax[a].qn  = sq_r[RW].ax[a].num[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW:0] t    [3];
    logic [RW:0] diff [3];
    logic        ge   [3];
    dv_t         dv_nxt;

    always_comb begin
      dv_nxt = dv_r[k];
      for (int a = 0; a < 3; a++) begin
        t[a]               = {dv_r[k].ax[a].rem, dv_r[k].ax[a].qn[QW-1]};
        diff[a]            = t[a] - {1'b0, dv_r[k].len};
        ge[a]              = (t[a] >= {1'b0, dv_r[k].len});
        dv_nxt.ax[a].rem   = ge[a] ? diff[a][RW-1:0] : t[a][RW-1:0];
        dv_nxt.ax[a].qn    = {dv_r[k].ax[a].qn[QW-2:0], ge[a]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1] <= dv_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- output
  // step capped at 2^(W+1), applied, clamped to the word range; no move at zero distance
  localparam logic [QW-1:0] STEP_LIMIT = QW'(1) << (W + 1);

  logic [QW-1:0]        o_q    [3];
  logic signed [OW-1:0] o_pe   [3];
  logic signed [OW-1:0] o_qe   [3];
  logic signed [OW-1:0] o_sum  [3];
  logic                 o_ovf  [3];
  logic signed [W-1:0]  o_new  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      o_q[a]   = (dv_r[QW].ax[a].ovf || dv_r[QW].ax[a].qn > STEP_LIMIT) ?
                 STEP_LIMIT : dv_r[QW].ax[a].qn;
      o_pe[a]  = OW'(dv_r[QW].ax[a].pos);
      o_qe[a]  = signed'({1'b0, o_q[a]});
      o_sum[a] = dv_r[QW].ax[a].neg ? (o_pe[a] + o_qe[a]) : (o_pe[a] - o_qe[a]);
      // out of range when the bits above the word's sign disagree
      o_ovf[a] = !((&o_sum[a][OW-1:W-1]) || !(|o_sum[a][OW-1:W-1]));
      if (dv_r[QW].zero) begin
        o_new[a] = dv_r[QW].ax[a].pos;
      end else if (o_ovf[a]) begin
        o_new[a] = o_sum[a][OW-1] ? signed'({1'b1, {(W-1){1'b0}}})
                                  : signed'({1'b0, {(W-1){1'b1}}});
      end else begin
        o_new[a] = o_sum[a][W-1:0];
      end
    end
  end

  logic                out_valid_r;
  logic signed [W-1:0] out_x_r, out_y_r, out_z_r;
  logic                out_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r    <= o_new[0];
      out_y_r    <= o_new[1];
      out_z_r    <= o_new[2];
      out_zero_r <= dv_r[QW].zero;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.new_x         = out_x_r;
  assign out_ch.new_y         = out_y_r;
  assign out_ch.new_z         = out_z_r;
  assign out_ch.zero_distance = out_zero_r;

endmodule

// ===== design/stt3d_checker.sv =====
`include "step_toward_target_3d_top_defines.svh"

module stt3d_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // reset empties the pipeline
  `STT3D_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)
  // first cycle out of reset shows nothing
  `STT3D_ASSERT_IMPLY(a_no_early_word, clk, rst_n, $rose(rst_n), !out_valid)
  // input side only waits while a finished word is stalled
  `STT3D_ASSERT_IMPLY(a_ready_law, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))
  // a stalled word stays offered
  `STT3D_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind step_toward_target_3d_top stt3d_checker u_stt3d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

// ===== tb/sv/tb_step_toward_target_3d_top.sv =====
`timescale 1ns / 100ps

module tb_step_toward_target_3d_top;
  import stt3d_pkg::*;

  localparam int CW         = 32;
  // settle margin for the end of the run, scaled with the coordinate width
  localparam int LATENCY    = 2 * CW + 12;
  localparam int CYCLE_CAP  = 600000;
  localparam logic [ASPECT_W-1:0] ASPECT_MAX = {ASPECT_W{1'b1}};

  // one input word: position, origin, target and step length
  typedef struct packed {
    logic signed [CW-1:0] pos_x, pos_y, pos_z;
    logic signed [CW-1:0] from_x, from_y, from_z;
    logic signed [CW-1:0] to_x, to_y, to_z;
    logic signed [CW-1:0] step_len;
  } move_word_t;

  // one result word: moved position plus the zero distance flag
  typedef struct packed {
    logic signed [CW-1:0] new_x, new_y, new_z;
    logic                 zero_distance;
  } moved_pos_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [ASPECT_W-1:0] cfg_wdata;

  stt3d_in_if  #(.COORD_WIDTH(CW)) in_ch ();
  stt3d_out_if #(.COORD_WIDTH(CW)) out_ch ();

  step_toward_target_3d_top #(.COORD_WIDTH(CW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // our own copy of the aspect register, updated on every write
  logic [ASPECT_W-1:0] aspect_shadow;
  moved_pos_t          pending_moves[$];
  int unsigned         mismatch_count;
  int unsigned         moves_checked;
  int unsigned         zero_dist_seen;
  int unsigned         words_sent;
  int unsigned         cycle_count;
  bit                  idling_on;

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d moves still pending",
               cycle_count, pending_moves.size());
      $display("tb_step_toward_target_3d_top NOT OK");
      $finish;
    end
  end

  // predictor: difference, aspect scaled distance, per-axis step, saturation
  function automatic moved_pos_t predict_move(move_word_t w, logic [ASPECT_W-1:0] asp);
    logic signed [63:0] pos[3];
    logic signed [63:0] dif[3];
    logic signed [63:0] stp;
    logic signed [63:0] r;
    logic [127:0]       dmag[3];
    logic [127:0]       smag;
    logic [127:0]       sx;
    logic [127:0]       sumsq;
    logic [127:0]       cand;
    logic [127:0]       quo;
    logic [127:0]       sat_lim;
    logic [63:0]        root;
    moved_pos_t         res;
    bit                 neg;
    pos[0] = 64'(w.pos_x);
    pos[1] = 64'(w.pos_y);
    pos[2] = 64'(w.pos_z);
    dif[0] = 64'(w.from_x) - 64'(w.to_x);
    dif[1] = 64'(w.from_y) - 64'(w.to_y);
    dif[2] = 64'(w.from_z) - 64'(w.to_z);
    stp    = 64'(w.step_len);
    for (int a = 0; a < 3; a++)
      dmag[a] = {64'd0, (dif[a] < 0) ? -dif[a] : dif[a]};
    smag = {64'd0, (stp < 0) ? -stp : stp};
    // x is scaled for the distance only, truncated toward zero
    sx    = (dmag[0] * {110'd0, asp}) >> ASPECT_FRAC;
    sumsq = sx * sx + dmag[1] * dmag[1] + dmag[2] * dmag[2];
    root  = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = {64'd0, root | (64'd1 << b)};
      if (cand * cand <= sumsq)
        root = cand[63:0];
    end
    sat_lim = 128'd1 << (CW + 1);
    for (int a = 0; a < 3; a++) begin
      r = pos[a];
      if (root != 0) begin
        quo = (smag * dmag[a]) / {64'd0, root};
        if (quo > sat_lim)
          quo = sat_lim;
        neg = (stp < 0) != (dif[a] < 0);
        r = neg ? r + 64'(quo) : r - 64'(quo);
      end
      if (r > 64'sh7FFF_FFFF)
        r = 64'sh7FFF_FFFF;
      else if (r < -64'sh8000_0000)
        r = -64'sh8000_0000;
      case (a)
        0: res.new_x = r[CW-1:0];
        1: res.new_y = r[CW-1:0];
        default: res.new_z = r[CW-1:0];
      endcase
    end
    res.zero_distance = (root == 0);
    return res;
  endfunction

  // random coordinate, biased toward small values, extremes and zero
  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      4: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom_range(0, 1) ? '0 : $urandom_range(0, 3);
    endcase
  endfunction

  function automatic move_word_t pick_move();
    move_word_t w;
    w.pos_x    = pick_coord();
    w.pos_y    = pick_coord();
    w.pos_z    = pick_coord();
    w.from_x   = pick_coord();
    w.from_y   = pick_coord();
    w.from_z   = pick_coord();
    w.to_x     = pick_coord();
    w.to_y     = pick_coord();
    w.to_z     = pick_coord();
    w.step_len = pick_coord();
    // sometimes put the target on the origin along some axes
    if ($urandom_range(0, 5) == 0) w.to_x = w.from_x;
    if ($urandom_range(0, 5) == 0) w.to_y = w.from_y;
    if ($urandom_range(0, 5) == 0) w.to_z = w.from_z;
    return w;
  endfunction

  // sender: optional idle burst, then hold the word until it is taken
  task automatic send_move(move_word_t w);
    int gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.pos_x    <= w.pos_x;
    in_ch.pos_y    <= w.pos_y;
    in_ch.pos_z    <= w.pos_z;
    in_ch.from_x   <= w.from_x;
    in_ch.from_y   <= w.from_y;
    in_ch.from_z   <= w.from_z;
    in_ch.to_x     <= w.to_x;
    in_ch.to_y     <= w.to_y;
    in_ch.to_z     <= w.to_z;
    in_ch.step_len <= w.step_len;
    do @(posedge clk); while (!in_ch.ready);
    pending_moves.push_back(predict_move(w, aspect_shadow));
    words_sent++;
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_moves.size() != 0) @(posedge clk);
  endtask

  // register writes only with the pipeline empty
  task automatic write_aspect(logic [ASPECT_W-1:0] val);
    drop_valid();
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    aspect_shadow = val;
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++)
      send_move(pick_move());
  endtask

  // result side: random stall bursts on ready
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 18);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // checker: every taken result against the oldest prediction
  always @(posedge clk) begin
    moved_pos_t got;
    moved_pos_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.new_x         = out_ch.new_x;
      got.new_y         = out_ch.new_y;
      got.new_z         = out_ch.new_z;
      got.zero_distance = out_ch.zero_distance;
      if (pending_moves.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: x=%0d y=%0d z=%0d zd=%0b",
                   got.new_x, got.new_y, got.new_z, got.zero_distance);
      end else begin
        want = pending_moves.pop_front();
        moves_checked++;
        if (got.zero_distance)
          zero_dist_seen++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch on result %0d: exp x=%0d y=%0d z=%0d zd=%0b, got x=%0d y=%0d z=%0d zd=%0b",
                     moves_checked, want.new_x, want.new_y, want.new_z,
                     want.zero_distance, got.new_x, got.new_y, got.new_z,
                     got.zero_distance);
        end
      end
    end
  end

  // corners of the fields, zero distance cases and saturation
  task automatic test_directed();
    move_word_t w;
    w = '0;
    send_move(w);                                   // everything zero
    w.pos_x = 32'sh0001_0000; w.step_len = 32'sh0001_0000;
    w.from_x = 32'sh0003_0000; w.from_y = 32'sh0004_0000;
    send_move(w);                                   // 3-4-5 triangle
    w.step_len = -w.step_len;
    send_move(w);                                   // negative step backs away
    w = '0;
    w.from_x = 32'sh7FFF_FFFF; w.to_x = 32'sh8000_0000;
    w.from_y = 32'sh8000_0000; w.to_y = 32'sh7FFF_FFFF;
    w.from_z = 32'sh7FFF_FFFF; w.to_z = 32'sh8000_0000;
    w.step_len = 32'sh7FFF_FFFF;
    send_move(w);                                   // widest differences
    w.step_len = 32'sh8000_0000;
    w.pos_x = 32'sh7FFF_FFFF; w.pos_y = 32'sh8000_0000; w.pos_z = 32'sh7FFF_FFFF;
    send_move(w);                                   // saturate both ways
    w = '0;
    w.from_x = 32'sd1; w.step_len = 32'sh7FFF_FFFF; w.pos_x = 32'sh8000_0000;
    send_move(w);                                   // tiny distance, huge ratio
    w = '0;
    w.pos_x = 32'sh7FFF_FFFF; w.pos_y = 32'sh8000_0000; w.pos_z = -32'sd1;
    w.from_x = 32'sh1234_5678; w.to_x = 32'sh1234_5678;
    w.from_y = -32'sd7; w.to_y = -32'sd7; w.from_z = 32'sh8000_0000;
    w.to_z = 32'sh8000_0000; w.step_len = 32'sh7FFF_FFFF;
    send_move(w);                                   // origin on target
    w = '0;
    w.from_z = -32'sd1; w.to_z = -32'sd1; w.from_y = 32'sd2;
    w.step_len = 32'sd1;
    send_move(w);                                   // one axis only, small step
    for (int i = 0; i < 10; i++)
      send_move(pick_move());
  endtask

  // x only differences with aspect zero give a zero distance; a y offset and random words follow
  task automatic test_aspect_zero();
    move_word_t w;
    write_aspect('0);
    w = pick_move();
    w.to_y = w.from_y; w.to_z = w.from_z;
    w.from_x = 32'sh0005_0000; w.to_x = -32'sh0005_0000;
    send_move(w);
    w.from_y = w.from_y + 32'sd1;
    send_move(w);
    send_random(150);
  endtask

  task automatic test_aspect_sweep();
    write_aspect(ASPECT_MAX);
    send_random(250);
    write_aspect(ASPECT_RESET);
    send_random(250);
    for (int i = 0; i < 3; i++) begin
      write_aspect(ASPECT_W'($urandom_range(0, ASPECT_MAX)));
      send_random(120);
    end
  endtask

  // sender holds off until the pipeline is empty, then refills it
  task automatic test_drain_and_refill();
    send_random(60);
    drop_valid();
    wait_drained();
    send_random(60);
  endtask

  // back to back on both sides for the tail of the run
  task automatic test_full_rate();
    idling_on = 1'b0;
    write_aspect(ASPECT_W'($urandom_range(0, ASPECT_MAX)));
    send_random(180);
    drop_valid();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.pos_x    = '0;
    in_ch.pos_y    = '0;
    in_ch.pos_z    = '0;
    in_ch.from_x   = '0;
    in_ch.from_y   = '0;
    in_ch.from_z   = '0;
    in_ch.to_x     = '0;
    in_ch.to_y     = '0;
    in_ch.to_z     = '0;
    in_ch.step_len = '0;
    out_ch.ready   = 1'b0;
    aspect_shadow  = ASPECT_RESET;
    mismatch_count = 0;
    moves_checked  = 0;
    zero_dist_seen = 0;
    words_sent     = 0;
    cycle_count    = 0;
    idling_on      = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_aspect_zero();
    test_aspect_sweep();
    test_drain_and_refill();
    test_full_rate();

    // let the pipeline empty, then a margin for stray words
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);

    $display("sent %0d words over several aspect settings incl. 0 and max, checked %0d moves",
             words_sent, moves_checked);
    $display("%0d zero distance results, %0d mismatches", zero_dist_seen, mismatch_count);
    if (mismatch_count == 0 && pending_moves.size() == 0) begin
      $display("tb_step_toward_target_3d_top OK");
    end else begin
      $display("tb_step_toward_target_3d_top NOT OK");
    end
    $finish;
  end

endmodule
